// ----- rtl/hptc_pkg.sv -----
// shared types, codes and microprogram for the compensation core
`default_nettype none
package hptc_pkg;

  // request opcodes
  localparam logic [1:0] OP_TEMP  = 2'd0;
  localparam logic [1:0] OP_PRESS = 2'd1;
  localparam logic [1:0] OP_HUM   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_CAL_T  = 3'd0;
  localparam logic [2:0] REG_CAL_PA = 3'd1;
  localparam logic [2:0] REG_CAL_PB = 3'd2;
  localparam logic [2:0] REG_CAL_PC = 3'd3;
  localparam logic [2:0] REG_CAL_HA = 3'd4;
  localparam logic [2:0] REG_CAL_HB = 3'd5;

  localparam int unsigned CfgWidth = 48;
  localparam int unsigned PcWidth  = 7;

  // program entry points
  localparam logic [PcWidth-1:0] PC_TEMP  = 7'd0;
  localparam logic [PcWidth-1:0] PC_PRESS = 7'd20;
  localparam logic [PcWidth-1:0] PC_HUM   = 7'd56;

  localparam logic [63:0] HUM_CLAMP = 64'd419430400;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [23:0] raw_reading;
  } in_req_t;

  typedef struct packed {
    logic signed [32:0] result_value;
    logic               status;
  } out_rsp_t;

  typedef enum logic [3:0] {
    ALU_ADD, ALU_SUB, ALU_MUL, ALU_ASR, ALU_SHL, ALU_SHR,
    ALU_DIV, ALU_CLAMP, ALU_FINE, ALU_DONE
  } alu_op_e;

  typedef enum logic [5:0] {
    SRC_R0, SRC_R1, SRC_R2, SRC_R3, SRC_R4,
    SRC_T1, SRC_T2, SRC_T3,
    SRC_P1, SRC_P2, SRC_P3, SRC_P4, SRC_P5, SRC_P6, SRC_P7, SRC_P8, SRC_P9,
    SRC_H1, SRC_H2, SRC_H3, SRC_H4, SRC_H5, SRC_H6,
    SRC_ADC, SRC_FINE,
    SRC_K1, SRC_K5, SRC_K128, SRC_K128000, SRC_K1048576, SRC_K3125,
    SRC_K76800, SRC_K16384, SRC_K2097152, SRC_K8192, SRC_K32768
  } src_e;

  typedef struct packed {
    alu_op_e    op;
    logic [2:0] dst;
    src_e       a;
    src_e       b;
    logic [5:0] sh;
  } instr_t;

  typedef struct packed {
    logic       start;
    alu_op_e    op;
    logic [63:0] a;
    logic [63:0] b;
    logic [5:0] sh;
    logic       w32;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] y;
  } alu_rsp_t;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_OUT} seq_st_e;
  typedef enum logic [1:0] {AS_IDLE, AS_MUL, AS_DIV, AS_FIX} alu_st_e;

  function automatic instr_t mk(alu_op_e op, logic [2:0] dst, src_e a, src_e b,
                                logic [5:0] sh);
    instr_t i;
    i.op = op; i.dst = dst; i.a = a; i.b = b; i.sh = sh;
    return i;
  endfunction

  // microprogram rom
  function automatic instr_t prog_rom(logic [PcWidth-1:0] pc);
    instr_t i;
    case (pc)
      // temperature, 32-bit wrap
      7'd0:  i = mk(ALU_SHR, 3'd0, SRC_ADC, SRC_R0, 6'd3);
      7'd1:  i = mk(ALU_SHL, 3'd1, SRC_T1, SRC_R0, 6'd1);
      7'd2:  i = mk(ALU_SUB, 3'd0, SRC_R0, SRC_R1, 6'd0);
      7'd3:  i = mk(ALU_MUL, 3'd0, SRC_R0, SRC_T2, 6'd0);
      7'd4:  i = mk(ALU_ASR, 3'd0, SRC_R0, SRC_R0, 6'd11);
      7'd5:  i = mk(ALU_SHR, 3'd1, SRC_ADC, SRC_R0, 6'd4);
      7'd6:  i = mk(ALU_SUB, 3'd1, SRC_R1, SRC_T1, 6'd0);
      7'd7:  i = mk(ALU_MUL, 3'd1, SRC_R1, SRC_R1, 6'd0);
      7'd8:  i = mk(ALU_ASR, 3'd1, SRC_R1, SRC_R0, 6'd12);
      7'd9:  i = mk(ALU_MUL, 3'd1, SRC_R1, SRC_T3, 6'd0);
      7'd10: i = mk(ALU_ASR, 3'd1, SRC_R1, SRC_R0, 6'd14);
      7'd11: i = mk(ALU_ADD, 3'd0, SRC_R0, SRC_R1, 6'd0);
      7'd12: i = mk(ALU_FINE, 3'd0, SRC_R0, SRC_R0, 6'd0);
      7'd13: i = mk(ALU_MUL, 3'd0, SRC_R0, SRC_K5, 6'd0);
      7'd14: i = mk(ALU_ADD, 3'd0, SRC_R0, SRC_K128, 6'd0);
      7'd15: i = mk(ALU_ASR, 3'd0, SRC_R0, SRC_R0, 6'd8);
      7'd16: i = mk(ALU_DONE, 3'd0, SRC_R0, SRC_R0, 6'd0);
      // pressure, 64-bit wrap
      7'd20: i = mk(ALU_SUB, 3'd0, SRC_FINE, SRC_K128000, 6'd0);
      7'd21: i = mk(ALU_MUL, 3'd1, SRC_R0, SRC_R0, 6'd0);
      7'd22: i = mk(ALU_MUL, 3'd2, SRC_R1, SRC_P6, 6'd0);
      7'd23: i = mk(ALU_MUL, 3'd3, SRC_R0, SRC_P5, 6'd0);
      7'd24: i = mk(ALU_SHL, 3'd3, SRC_R3, SRC_R0, 6'd17);
      7'd25: i = mk(ALU_ADD, 3'd2, SRC_R2, SRC_R3, 6'd0);
      7'd26: i = mk(ALU_SHL, 3'd3, SRC_P4, SRC_R0, 6'd35);
      7'd27: i = mk(ALU_ADD, 3'd2, SRC_R2, SRC_R3, 6'd0);
      7'd28: i = mk(ALU_MUL, 3'd1, SRC_R1, SRC_P3, 6'd0);
      7'd29: i = mk(ALU_ASR, 3'd1, SRC_R1, SRC_R0, 6'd8);
      7'd30: i = mk(ALU_MUL, 3'd3, SRC_R0, SRC_P2, 6'd0);
      7'd31: i = mk(ALU_SHL, 3'd3, SRC_R3, SRC_R0, 6'd12);
      7'd32: i = mk(ALU_ADD, 3'd0, SRC_R1, SRC_R3, 6'd0);
      7'd33: i = mk(ALU_SHL, 3'd1, SRC_K1, SRC_R0, 6'd47);
      7'd34: i = mk(ALU_ADD, 3'd0, SRC_R1, SRC_R0, 6'd0);
      7'd35: i = mk(ALU_MUL, 3'd0, SRC_R0, SRC_P1, 6'd0);
      7'd36: i = mk(ALU_ASR, 3'd0, SRC_R0, SRC_R0, 6'd33);
      7'd37: i = mk(ALU_SUB, 3'd1, SRC_K1048576, SRC_ADC, 6'd0);
      7'd38: i = mk(ALU_SHL, 3'd1, SRC_R1, SRC_R0, 6'd31);
      7'd39: i = mk(ALU_SUB, 3'd1, SRC_R1, SRC_R2, 6'd0);
      7'd40: i = mk(ALU_MUL, 3'd1, SRC_R1, SRC_K3125, 6'd0);
      7'd41: i = mk(ALU_DIV, 3'd1, SRC_R1, SRC_R0, 6'd0);
      7'd42: i = mk(ALU_ASR, 3'd2, SRC_R1, SRC_R0, 6'd13);
      7'd43: i = mk(ALU_MUL, 3'd3, SRC_P9, SRC_R2, 6'd0);
      7'd44: i = mk(ALU_MUL, 3'd3, SRC_R3, SRC_R2, 6'd0);
      7'd45: i = mk(ALU_ASR, 3'd3, SRC_R3, SRC_R0, 6'd25);
      7'd46: i = mk(ALU_MUL, 3'd4, SRC_P8, SRC_R1, 6'd0);
      7'd47: i = mk(ALU_ASR, 3'd4, SRC_R4, SRC_R0, 6'd19);
      7'd48: i = mk(ALU_ADD, 3'd1, SRC_R1, SRC_R3, 6'd0);
      7'd49: i = mk(ALU_ADD, 3'd1, SRC_R1, SRC_R4, 6'd0);
      7'd50: i = mk(ALU_ASR, 3'd1, SRC_R1, SRC_R0, 6'd8);
      7'd51: i = mk(ALU_SHL, 3'd2, SRC_P7, SRC_R0, 6'd4);
      7'd52: i = mk(ALU_ADD, 3'd1, SRC_R1, SRC_R2, 6'd0);
      7'd53: i = mk(ALU_DONE, 3'd0, SRC_R1, SRC_R0, 6'd0);
      // humidity, 32-bit wrap
      7'd56: i = mk(ALU_SUB, 3'd0, SRC_FINE, SRC_K76800, 6'd0);
      7'd57: i = mk(ALU_SHL, 3'd1, SRC_ADC, SRC_R0, 6'd14);
      7'd58: i = mk(ALU_SHL, 3'd2, SRC_H4, SRC_R0, 6'd20);
      7'd59: i = mk(ALU_SUB, 3'd1, SRC_R1, SRC_R2, 6'd0);
      7'd60: i = mk(ALU_MUL, 3'd2, SRC_H5, SRC_R0, 6'd0);
      7'd61: i = mk(ALU_SUB, 3'd1, SRC_R1, SRC_R2, 6'd0);
      7'd62: i = mk(ALU_ADD, 3'd1, SRC_R1, SRC_K16384, 6'd0);
      7'd63: i = mk(ALU_ASR, 3'd1, SRC_R1, SRC_R0, 6'd15);
      7'd64: i = mk(ALU_MUL, 3'd2, SRC_R0, SRC_H6, 6'd0);
      7'd65: i = mk(ALU_ASR, 3'd2, SRC_R2, SRC_R0, 6'd10);
      7'd66: i = mk(ALU_MUL, 3'd3, SRC_R0, SRC_H3, 6'd0);
      7'd67: i = mk(ALU_ASR, 3'd3, SRC_R3, SRC_R0, 6'd11);
      7'd68: i = mk(ALU_ADD, 3'd3, SRC_R3, SRC_K32768, 6'd0);
      7'd69: i = mk(ALU_MUL, 3'd2, SRC_R2, SRC_R3, 6'd0);
      7'd70: i = mk(ALU_ASR, 3'd2, SRC_R2, SRC_R0, 6'd10);
      7'd71: i = mk(ALU_ADD, 3'd2, SRC_R2, SRC_K2097152, 6'd0);
      7'd72: i = mk(ALU_MUL, 3'd2, SRC_R2, SRC_H2, 6'd0);
      7'd73: i = mk(ALU_ADD, 3'd2, SRC_R2, SRC_K8192, 6'd0);
      7'd74: i = mk(ALU_ASR, 3'd2, SRC_R2, SRC_R0, 6'd14);
      7'd75: i = mk(ALU_MUL, 3'd1, SRC_R1, SRC_R2, 6'd0);
      7'd76: i = mk(ALU_ASR, 3'd2, SRC_R1, SRC_R0, 6'd15);
      7'd77: i = mk(ALU_MUL, 3'd2, SRC_R2, SRC_R2, 6'd0);
      7'd78: i = mk(ALU_ASR, 3'd2, SRC_R2, SRC_R0, 6'd7);
      7'd79: i = mk(ALU_MUL, 3'd2, SRC_R2, SRC_H1, 6'd0);
      7'd80: i = mk(ALU_ASR, 3'd2, SRC_R2, SRC_R0, 6'd4);
      7'd81: i = mk(ALU_SUB, 3'd1, SRC_R1, SRC_R2, 6'd0);
      7'd82: i = mk(ALU_CLAMP, 3'd1, SRC_R1, SRC_R0, 6'd0);
      7'd83: i = mk(ALU_SHR, 3'd1, SRC_R1, SRC_R0, 6'd12);
      7'd84: i = mk(ALU_DONE, 3'd0, SRC_R1, SRC_R0, 6'd0);
      default: i = mk(ALU_DONE, 3'd0, SRC_R0, SRC_R0, 6'd0);
    endcase
    return i;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/humidity_pressure_temp_compensation_core.sv -----
// top level: request handshake, calibration registers and microcode sequencer
// Integer compensation of one temperature, pressure or humidity reading per
// request. The user must write calibration words through the cfg port only
// while idle; the block itself does not enforce this. A small sequencer steps
// a microprogram over one shared unit holding a 32x32 multiplier (three
// passes per 64-bit product) and a one-bit-a-cycle divider. The 64-bit
// divide runs as issue, 64 quotient bits, sign fix and write-back. A zero
// pressure divisor ends the program early with status set. Unknown opcodes
// show a zero result in the cycle after the accepting edge. The block takes
// one request at a time and is ready again once the result has been taken.
`default_nettype none
module humidity_pressure_temp_compensation_core import hptc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire in_req_t             in_req_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output out_rsp_t                 out_rsp_o,
  input  wire logic                cfg_we_i,
  input  wire logic [2:0]          cfg_idx_i,
  input  wire logic [CfgWidth-1:0] cfg_data_i
);

  seq_st_e st_q, st_d;
  logic [PcWidth-1:0] pc_q;
  logic [1:0]  op_q;
  logic [23:0] adc_q;
  logic [31:0] fine_q;
  logic [63:0] r_q [5];
  logic [47:0] cal_t_q, cal_pa_q, cal_pb_q, cal_pc_q;
  logic [31:0] cal_ha_q;
  logic [39:0] cal_hb_q;
  out_rsp_t    rsp_q;

  instr_t      ins;
  logic [63:0] opa, opb;
  alu_req_t    alu_req;
  alu_rsp_t    alu_rsp;
  logic        in_acc;

  function automatic logic [63:0] sx16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // operand select
  function automatic logic [63:0] fetch(src_e s, logic [63:0] r0, logic [63:0] r1,
                                        logic [63:0] r2, logic [63:0] r3,
                                        logic [63:0] r4, logic [47:0] ct,
                                        logic [47:0] pa, logic [47:0] pb,
                                        logic [47:0] pcw, logic [31:0] ha,
                                        logic [39:0] hb, logic [23:0] adc,
                                        logic [31:0] fine);
    logic [63:0] v;
    case (s)
      SRC_R0:       v = r0;
      SRC_R1:       v = r1;
      SRC_R2:       v = r2;
      SRC_R3:       v = r3;
      SRC_R4:       v = r4;
      SRC_T1:       v = {48'd0, ct[15:0]};
      SRC_T2:       v = sx16(ct[31:16]);
      SRC_T3:       v = sx16(ct[47:32]);
      SRC_P1:       v = {48'd0, pa[15:0]};
      SRC_P2:       v = sx16(pa[31:16]);
      SRC_P3:       v = sx16(pa[47:32]);
      SRC_P4:       v = sx16(pb[15:0]);
      SRC_P5:       v = sx16(pb[31:16]);
      SRC_P6:       v = sx16(pb[47:32]);
      SRC_P7:       v = sx16(pcw[15:0]);
      SRC_P8:       v = sx16(pcw[31:16]);
      SRC_P9:       v = sx16(pcw[47:32]);
      SRC_H1:       v = {56'd0, ha[7:0]};
      SRC_H2:       v = sx16(ha[23:8]);
      SRC_H3:       v = {56'd0, ha[31:24]};
      SRC_H4:       v = sx16(hb[15:0]);
      SRC_H5:       v = sx16(hb[31:16]);
      SRC_H6:       v = {{56{hb[39]}}, hb[39:32]};
      SRC_ADC:      v = {40'd0, adc};
      SRC_FINE:     v = {{32{fine[31]}}, fine};
      SRC_K1:       v = 64'd1;
      SRC_K5:       v = 64'd5;
      SRC_K128:     v = 64'd128;
      SRC_K128000:  v = 64'd128000;
      SRC_K1048576: v = 64'd1048576;
      SRC_K3125:    v = 64'd3125;
      SRC_K76800:   v = 64'd76800;
      SRC_K16384:   v = 64'd16384;
      SRC_K2097152: v = 64'd2097152;
      SRC_K8192:    v = 64'd8192;
      SRC_K32768:   v = 64'd32768;
      default:      v = 64'd0;
    endcase
    return v;
  endfunction

  assign in_acc = in_valid_i && in_ready_o;
  assign ins    = prog_rom(pc_q);
  assign opa    = fetch(ins.a, r_q[0], r_q[1], r_q[2], r_q[3], r_q[4], cal_t_q,
                        cal_pa_q, cal_pb_q, cal_pc_q, cal_ha_q, cal_hb_q, adc_q,
                        fine_q);
  assign opb    = fetch(ins.b, r_q[0], r_q[1], r_q[2], r_q[3], r_q[4], cal_t_q,
                        cal_pa_q, cal_pb_q, cal_pc_q, cal_ha_q, cal_hb_q, adc_q,
                        fine_q);

  // unit request
  always_comb begin
    alu_req.start = (st_q == ST_ISSUE) && !(ins.op == ALU_DONE || ins.op == ALU_FINE ||
                    (ins.op == ALU_DIV && opb == 64'd0));
    alu_req.op    = ins.op;
    alu_req.a     = opa;
    alu_req.b     = opb;
    alu_req.sh    = ins.sh;
    alu_req.w32   = (op_q != OP_PRESS);
  end

  hptc_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_req_i.opcode == OP_TEMP || in_req_i.opcode == OP_PRESS ||
              in_req_i.opcode == OP_HUM) st_d = ST_ISSUE;
          else st_d = ST_OUT;
        end
      end
      ST_ISSUE: begin
        if (ins.op == ALU_DONE || (ins.op == ALU_DIV && opb == 64'd0)) st_d = ST_OUT;
        else if (ins.op != ALU_FINE) st_d = ST_WAIT;
      end
      ST_WAIT: if (alu_rsp.done) st_d = ST_ISSUE;
      ST_OUT:  if (out_ready_i) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready_o  = (st_q == ST_IDLE);
    out_valid_o = (st_q == ST_OUT);
    out_rsp_o   = rsp_q;
  end

  // control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      fine_q   <= '0;
      cal_t_q  <= '0;
      cal_pa_q <= '0;
      cal_pb_q <= '0;
      cal_pc_q <= '0;
      cal_ha_q <= '0;
      cal_hb_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_ISSUE && ins.op == ALU_FINE) fine_q <= opa[31:0];
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CAL_T:  cal_t_q  <= cfg_data_i;
          REG_CAL_PA: cal_pa_q <= cfg_data_i;
          REG_CAL_PB: cal_pb_q <= cfg_data_i;
          REG_CAL_PC: cal_pc_q <= cfg_data_i;
          REG_CAL_HA: cal_ha_q <= cfg_data_i[31:0];
          REG_CAL_HB: cal_hb_q <= cfg_data_i[39:0];
          default: ;
        endcase
      end
    end
  end

  // sequencer datapath
  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_q  <= in_req_i.opcode;
          adc_q <= (in_req_i.opcode == OP_HUM) ? {8'd0, in_req_i.raw_reading[15:0]}
                                                : in_req_i.raw_reading;
          rsp_q <= '0;
          case (in_req_i.opcode)
            OP_TEMP:  pc_q <= PC_TEMP;
            OP_PRESS: pc_q <= PC_PRESS;
            default:  pc_q <= PC_HUM;
          endcase
        end
      end
      ST_ISSUE: begin
        if (ins.op == ALU_FINE) pc_q <= pc_q + 7'd1;
        if (ins.op == ALU_DONE) begin
          rsp_q.status <= 1'b0;
          if (op_q == OP_PRESS) rsp_q.result_value <= $signed({1'b0, opa[31:0]});
          else rsp_q.result_value <= $signed(opa[32:0]);
        end else if (ins.op == ALU_DIV && opb == 64'd0) begin
          rsp_q.status       <= 1'b1;
          rsp_q.result_value <= '0;
        end
      end
      ST_WAIT: begin
        if (alu_rsp.done) begin
          r_q[ins.dst] <= alu_rsp.y;
          pc_q         <= pc_q + 7'd1;
        end
      end
      default: pc_q <= pc_q;
    endcase
  end

  // checks
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o) else $error("ready right after accept");

  a_status_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.status) |-> (op_q == OP_PRESS))
    else $error("divisor status on non-pressure request");

  a_start_in_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_req.start |=> (st_q == ST_WAIT)) else $error("unit started outside issue");

endmodule
`default_nettype wire

// ----- rtl/hptc_alu.sv -----
// shared multi-cycle arithmetic unit: add, subtract, shift, clamp, 64-bit multiply and divide
`default_nettype none
module hptc_alu import hptc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire alu_req_t req_i,
  output alu_rsp_t      rsp_o
);

  alu_st_e st_q, st_d;
  logic [63:0] a_q, b_q, acc_q, y_q;
  logic [64:0] rem_q;
  logic [5:0]  cnt_q;
  logic        neg_q, w32_q, done_q;

  logic [31:0] mul_x, mul_y;
  logic [63:0] prod, mul_sum, simple_y;
  logic [64:0] rem_sh, rem_diff;
  logic [63:0] ua, ub;

  // one 32x32 multiplier, operand halves picked by step
  assign mul_x   = (cnt_q == 6'd2) ? a_q[63:32] : a_q[31:0];
  assign mul_y   = (cnt_q == 6'd1) ? b_q[63:32] : b_q[31:0];
  assign prod    = mul_x * mul_y;
  assign mul_sum = acc_q + {prod[31:0], 32'd0};

  // divider step on magnitudes
  assign ua       = req_i.a[63] ? (64'd0 - req_i.a) : req_i.a;
  assign ub       = req_i.b[63] ? (64'd0 - req_i.b) : req_i.b;
  assign rem_sh   = {rem_q[63:0], a_q[63]};
  assign rem_diff = rem_sh - {1'b0, b_q};

  // combinational result of the simple operations
  always_comb begin
    case (req_i.op)
      ALU_ADD:   simple_y = req_i.a + req_i.b;
      ALU_SUB:   simple_y = req_i.a - req_i.b;
      ALU_ASR:   simple_y = $unsigned($signed(req_i.a) >>> req_i.sh);
      ALU_SHL:   simple_y = req_i.a << req_i.sh;
      ALU_SHR:   simple_y = req_i.a >> req_i.sh;
      ALU_CLAMP: begin
        if (req_i.a[63]) simple_y = 64'd0;
        else if (req_i.a > HUM_CLAMP) simple_y = HUM_CLAMP;
        else simple_y = req_i.a;
      end
      default:   simple_y = req_i.a;
    endcase
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      AS_IDLE: begin
        if (req_i.start && req_i.op == ALU_MUL) st_d = AS_MUL;
        else if (req_i.start && req_i.op == ALU_DIV) st_d = AS_DIV;
      end
      AS_MUL: if (cnt_q == 6'd2) st_d = AS_IDLE;
      AS_DIV: if (cnt_q == 6'd63) st_d = AS_FIX;
      AS_FIX: st_d = AS_IDLE;
      default: st_d = AS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= AS_IDLE;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      st_q   <= st_d;
      done_q <= 1'b0;
      case (st_q)
        AS_IDLE: begin
          cnt_q <= '0;
          if (req_i.start) begin
            done_q <= !(req_i.op == ALU_MUL || req_i.op == ALU_DIV);
          end
        end
        AS_MUL: begin
          cnt_q  <= cnt_q + 6'd1;
          done_q <= (cnt_q == 6'd2);
        end
        AS_DIV: cnt_q <= cnt_q + 6'd1;
        AS_FIX: done_q <= 1'b1;
        default: cnt_q <= '0;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (st_q)
      AS_IDLE: begin
        w32_q <= req_i.w32;
        if (req_i.start && req_i.op == ALU_DIV) begin
          a_q   <= ua;
          b_q   <= ub;
          rem_q <= '0;
          neg_q <= req_i.a[63] ^ req_i.b[63];
        end else begin
          a_q <= req_i.a;
          b_q <= req_i.b;
        end
        if (req_i.w32) y_q <= {{32{simple_y[31]}}, simple_y[31:0]};
        else y_q <= simple_y;
      end
      AS_MUL: begin
        if (cnt_q == 6'd0) acc_q <= prod;
        else acc_q <= mul_sum;
        if (w32_q) y_q <= {{32{mul_sum[31]}}, mul_sum[31:0]};
        else y_q <= mul_sum;
      end
      AS_DIV: begin
        a_q <= {a_q[62:0], !rem_diff[64]};
        if (!rem_diff[64]) rem_q <= rem_diff;
        else rem_q <= rem_sh;
      end
      AS_FIX: y_q <= neg_q ? (64'd0 - a_q) : a_q;
      default: y_q <= y_q;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.y    = y_q;

endmodule
`default_nettype wire
